@@ rtl/core/cau_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg: complex arithmetic unit shared types
// Beat structs, command codes, internal widths and the Q8.8 saturation helper.
// ----------------------------------------------------------------------------
package cau_pkg;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } cmd_t;

    localparam int NUM_W  = 33;   // exact sum of two Q16.16 products
    localparam int DEN_W  = 32;   // b_re^2 + b_im^2
    localparam int MAG_W  = 32;   // |num|
    localparam int QBITS  = 17;   // quotient bits kept, larger values saturate
    localparam int WIDE_W = 26;   // pre-saturation result
    localparam int LOW_W  = 9;    // mag bits shifted in during the steps

    typedef struct packed {
        logic [1:0]         command;
        logic signed [15:0] a_re;
        logic signed [15:0] a_im;
        logic signed [15:0] b_re;
        logic signed [15:0] b_im;
    } in_t;

    typedef struct packed {
        logic signed [15:0] res_re;
        logic signed [15:0] res_im;
        logic               saturated;
        logic               div_zero;
    } out_t;

    typedef struct packed {
        logic signed [NUM_W-1:0]  num_re;
        logic signed [NUM_W-1:0]  num_im;
        logic [DEN_W-1:0]         den;
        logic [1:0]               cmd;
        logic signed [WIDE_W-1:0] wide_re;
        logic signed [WIDE_W-1:0] wide_im;
        logic                     dz;
    } front_t;

    typedef struct packed {
        logic [1:0]               cmd;
        logic signed [WIDE_W-1:0] wide_re;
        logic signed [WIDE_W-1:0] wide_im;
        logic                     dz;
    } side_t;

    typedef struct packed {
        logic signed [15:0] val;
        logic               sat;
    } sat_t;

    function automatic sat_t sat16(input logic signed [WIDE_W-1:0] v);
        sat_t r;
        if (v > WIDE_W'(32767)) begin
            r.val = 16'sh7FFF;
            r.sat = 1'b1;
        end else if (v < -WIDE_W'(32768)) begin
            r.val = 16'sh8000;
            r.sat = 1'b1;
        end else begin
            r.val = v[15:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

endpackage

@@ rtl/core/cau_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_front: product and sum stages
// Stage 0 forms the six products and the add/sub sums, stage 1 the numerators,
// the divisor norm and the truncated multiply result.
// ----------------------------------------------------------------------------
module cau_front (
    input  logic          aclk,
    input  logic [1:0]    en,
    input  cau_pkg::in_t  s_in,
    output cau_pkg::front_t f
);
    import cau_pkg::*;

    logic signed [31:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [31:0] n_rr_reg, n_ii_reg;
    logic signed [16:0] as_re_reg, as_im_reg;
    logic [1:0]         cmd_reg;
    logic               zb_reg;
    front_t             f_reg;

    logic signed [16:0] as_re_next, as_im_next;
    logic signed [32:0] mre, mim;
    front_t             f_next;

    always_comb begin
        if (s_in.command == CMD_SUB) begin
            as_re_next = {s_in.a_re[15], s_in.a_re} - {s_in.b_re[15], s_in.b_re};
            as_im_next = {s_in.a_im[15], s_in.a_im} - {s_in.b_im[15], s_in.b_im};
        end else begin
            as_re_next = {s_in.a_re[15], s_in.a_re} + {s_in.b_re[15], s_in.b_re};
            as_im_next = {s_in.a_im[15], s_in.a_im} + {s_in.b_im[15], s_in.b_im};
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            p_rr_reg  <= s_in.a_re * s_in.b_re;
            p_ii_reg  <= s_in.a_im * s_in.b_im;
            p_ri_reg  <= s_in.a_re * s_in.b_im;
            p_ir_reg  <= s_in.a_im * s_in.b_re;
            n_rr_reg  <= s_in.b_re * s_in.b_re;
            n_ii_reg  <= s_in.b_im * s_in.b_im;
            as_re_reg <= as_re_next;
            as_im_reg <= as_im_next;
            cmd_reg   <= s_in.command;
            zb_reg    <= (s_in.b_re == 16'sd0) && (s_in.b_im == 16'sd0);
        end
    end

    always_comb begin
        mre = {p_rr_reg[31], p_rr_reg} - {p_ii_reg[31], p_ii_reg};
        mim = {p_ri_reg[31], p_ri_reg} + {p_ir_reg[31], p_ir_reg};
        f_next.num_re = {p_rr_reg[31], p_rr_reg} + {p_ii_reg[31], p_ii_reg};
        f_next.num_im = {p_ir_reg[31], p_ir_reg} - {p_ri_reg[31], p_ri_reg};
        f_next.den    = n_rr_reg[31:0] + n_ii_reg[31:0];
        f_next.cmd    = cmd_reg;
        f_next.dz     = (cmd_reg == CMD_DIV) && zb_reg;
        if (cmd_reg == CMD_MUL) begin
            // arithmetic shift = floor toward minus infinity
            f_next.wide_re = {mre[32], mre[32:8]};
            f_next.wide_im = {mim[32], mim[32:8]};
        end else begin
            f_next.wide_re = {{(WIDE_W-17){as_re_reg[16]}}, as_re_reg};
            f_next.wide_im = {{(WIDE_W-17){as_im_reg[16]}}, as_im_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            f_reg <= f_next;
        end
    end

    assign f = f_reg;

endmodule

@@ rtl/core/cau_div_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_div_lane: pipelined restoring divider for one result part
// Computes (|num| << 8) / den, one quotient bit per stage, with an overflow
// flag when the quotient needs more than QBITS bits.
// ----------------------------------------------------------------------------
module cau_div_lane (
    input  logic                             aclk,
    input  logic [cau_pkg::QBITS:0]          en,
    input  logic signed [cau_pkg::NUM_W-1:0] num,
    input  logic [cau_pkg::DEN_W-1:0]        den,
    output logic [cau_pkg::QBITS-1:0]        quo,
    output logic                             ovf,
    output logic                             neg
);
    import cau_pkg::*;

    logic [MAG_W-1:0] mag_reg;
    logic [DEN_W-1:0] den0_reg;
    logic             neg0_reg;
    logic [NUM_W-1:0] abs_v;

    assign abs_v = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            mag_reg  <= abs_v[MAG_W-1:0];
            den0_reg <= den;
            neg0_reg <= num[NUM_W-1];
        end
    end

    logic [DEN_W-1:0] rem_reg [QBITS];
    logic [QBITS-1:0] quo_reg [QBITS];
    logic [DEN_W-1:0] den_reg [QBITS];
    logic [LOW_W-1:0] low_reg [QBITS];
    logic             neg_reg [QBITS];
    logic             ovf_reg [QBITS];

    for (genvar k = 0; k < QBITS; k++) begin : g_step
        localparam int B = QBITS - 1 - k;   // dividend bit shifted in here
        logic [DEN_W-1:0] rem_in, den_in, rem_next;
        logic [QBITS-1:0] quo_in;
        logic [LOW_W-1:0] low_in;
        logic             neg_in, ovf_in, din, ge;
        logic [DEN_W:0]   trial, diff;

        if (k == 0) begin : g_first
            assign rem_in = DEN_W'(mag_reg[MAG_W-1:LOW_W]);
            assign den_in = den0_reg;
            assign quo_in = '0;
            assign low_in = mag_reg[LOW_W-1:0];
            assign neg_in = neg0_reg;
            assign ovf_in = DEN_W'(mag_reg[MAG_W-1:LOW_W]) >= den0_reg;
        end else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign low_in = low_reg[k-1];
            assign neg_in = neg_reg[k-1];
            assign ovf_in = ovf_reg[k-1];
        end

        if (B >= 8) begin : g_bit
            assign din = low_in[B-8];
        end else begin : g_zero
            assign din = 1'b0;
        end

        assign trial    = {rem_in, din};
        assign ge       = trial >= {1'b0, den_in};
        assign diff     = trial - {1'b0, den_in};
        assign rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

        always_ff @(posedge aclk) begin
            if (en[k+1]) begin
                rem_reg[k] <= rem_next;
                quo_reg[k] <= {quo_in[QBITS-2:0], ge};
                den_reg[k] <= den_in;
                low_reg[k] <= low_in;
                neg_reg[k] <= neg_in;
                ovf_reg[k] <= ovf_in;
            end
        end
    end

    assign quo = quo_reg[QBITS-1];
    assign ovf = ovf_reg[QBITS-1];
    assign neg = neg_reg[QBITS-1];

endmodule

@@ rtl/core/complex_arith_unit_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arith_unit_core: Q8.8 complex add / sub / mul / div
// Two product stages, two 18-stage divider lanes, one saturation stage.
// ----------------------------------------------------------------------------
//  channel   dir   handshake           beat
//  s_        in    s_valid / s_ready   command, a_re, a_im, b_re, b_im
//  m_        out   m_valid / m_ready   res_re, res_im, saturated, div_zero
//
// One beat per cycle while m_ready does not stall the output; the depth is set
// by the divider lanes, one quotient bit per stage.
// Every stage has a valid bit; a stage loads when empty or when the next
// stage moves, so bubbles close up under a stall and nothing is dropped.
// aresetn (synchronous) clears the valid bits only.
// ----------------------------------------------------------------------------
module complex_arith_unit_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  cau_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output cau_pkg::out_t  m_data
);
    import cau_pkg::*;

    localparam int LANE_ST = QBITS + 1;
    localparam int NST     = 2 + LANE_ST + 1;

    logic [NST-1:0] v_reg;
    logic [NST-1:0] en;

    assign en[NST-1] = !v_reg[NST-1] || m_ready;
    for (genvar i = 0; i < NST - 1; i++) begin : g_en
        assign en[i] = !v_reg[i] || en[i+1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int i = 0; i < NST; i++) begin
                if (en[i]) begin
                    v_reg[i] <= (i == 0) ? s_valid : v_reg[(i == 0) ? 0 : i - 1];
                end
            end
        end
    end

    assign s_ready = en[0];
    assign m_valid = v_reg[NST-1];

    front_t f;

    cau_front u_front (
        .aclk (aclk),
        .en   (en[1:0]),
        .s_in (s_data),
        .f    (f)
    );

    logic [QBITS-1:0] quo_re, quo_im;
    logic             ovf_re, ovf_im, neg_re, neg_im;

    cau_div_lane u_div_re (
        .aclk (aclk),
        .en   (en[2 +: LANE_ST]),
        .num  (f.num_re),
        .den  (f.den),
        .quo  (quo_re),
        .ovf  (ovf_re),
        .neg  (neg_re)
    );

    cau_div_lane u_div_im (
        .aclk (aclk),
        .en   (en[2 +: LANE_ST]),
        .num  (f.num_im),
        .den  (f.den),
        .quo  (quo_im),
        .ovf  (ovf_im),
        .neg  (neg_im)
    );

    // non-divide results ride alongside the divider lanes
    side_t side_reg [LANE_ST];

    always_ff @(posedge aclk) begin
        for (int i = 0; i < LANE_ST; i++) begin
            if (en[2+i]) begin
                if (i == 0) begin
                    side_reg[i] <= '{cmd: f.cmd, wide_re: f.wide_re,
                                     wide_im: f.wide_im, dz: f.dz};
                end else begin
                    side_reg[i] <= side_reg[(i == 0) ? 0 : i - 1];
                end
            end
        end
    end

    function automatic logic signed [WIDE_W-1:0] div_val(
        input logic [QBITS-1:0] q,
        input logic             o,
        input logic             n
    );
        logic signed [WIDE_W-1:0] m;
        m = o ? WIDE_W'(1 << 20) : WIDE_W'(q);
        return n ? -m : m;
    endfunction

    side_t                    sd;
    logic signed [WIDE_W-1:0] fin_re, fin_im;
    sat_t                     s_re, s_im;
    out_t                     out_next, out_reg;

    assign sd = side_reg[LANE_ST-1];

    always_comb begin
        if (sd.cmd == CMD_DIV) begin
            if (sd.dz) begin
                fin_re = '0;
                fin_im = '0;
            end else begin
                fin_re = div_val(quo_re, ovf_re, neg_re);
                fin_im = div_val(quo_im, ovf_im, neg_im);
            end
        end else begin
            fin_re = sd.wide_re;
            fin_im = sd.wide_im;
        end
        s_re = sat16(fin_re);
        s_im = sat16(fin_im);
        out_next.res_re    = s_re.val;
        out_next.res_im    = s_im.val;
        out_next.saturated = s_re.sat | s_im.sat;
        out_next.div_zero  = sd.dz;
    end

    always_ff @(posedge aclk) begin
        if (en[NST-1]) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

    a_no_sat_on_dz: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.saturated && m_data.div_zero))
        else $error("saturated and div_zero both set");

    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.div_zero) |-> (m_data.res_re == 16'sd0 && m_data.res_im == 16'sd0))
        else $error("divide by zero gave nonzero result");

    a_full_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (&v_reg))
        else $error("input stalled with a bubble in the pipeline");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

endmodule
